// File: sv/msb_pkg.sv
// ----------------------------------------------------------------------------
// Merge sort buffer package
// Shared word width and word type for the merge sort buffer.
// ----------------------------------------------------------------------------
package msb_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] word_type;

endpackage

// File: sv/msb_ram.sv
// ----------------------------------------------------------------------------
// Merge sort buffer RAM
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module msb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule

// File: sv/merge_sort_buffer.sv
// Loading: req_ready is low from the closing word until the last sorted word
// is handed to the output register. Sorting: ceil(log2(n)) merge passes (one
// for a single word) through one shared compare unit; then one sorted word per
// cycle as rsp_ready allows. Reset (synchronous, active high) clears count,
// the drop and valid flags, state and source select; the two buffers are not
// cleared.
// ----------------------------------------------------------------------------
// Merge sort buffer
// Collects a sequence of signed words, sorts it ascending by bottom-up stable
// merge sort over two ping-pong buffers, and streams the sorted words out.
// ----------------------------------------------------------------------------
module merge_sort_buffer
   import msb_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  word_type req_value,
   input  logic     req_is_last,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output word_type rsp_sorted_value,
   output logic     rsp_end_of_run,
   output logic     rsp_overflow
);

   // AW indexes a buffer, CW holds a count up to MAX_ITEMS, SW holds the
   // segment arithmetic (lo + 2 * width stays below three times the count).
   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int SW = CW + 2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SEG,
      ST_MERGE,
      ST_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             drop_ff, drop_in;
   logic [SW-1:0]    width_ff, width_in;
   logic [SW-1:0]    lo_ff, lo_in;
   logic [CW-1:0]    mid_ff, mid_in;
   logic [CW-1:0]    hi_ff, hi_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [CW-1:0]    k_ff, k_in;
   logic             src_ff, src_in;
   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_value_ff, rsp_value_in;
   logic             rsp_end_ff, rsp_end_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   // Buffer ports. Buffer A takes the loaded words; during a pass the source
   // buffer is chosen by src_ff and the other one receives the merged run.
   logic             we_a, we_b;
   logic [AW-1:0]    waddr_a;
   word_type         wdata_a;
   logic [DATA_W-1:0] rd_a0, rd_a1, rd_b0, rd_b1;
   word_type         head_left, head_right, merge_data;

   logic             req_fire, load_we, count_full;
   logic [CW-1:0]    count_after;
   logic [SW-1:0]    n_wide, seg_mid, seg_hi, width_dbl;
   logic [CW-1:0]    mid_clip, hi_clip;
   logic             i_live, j_live, take_left, out_fire;

   assign req_ready   = (state_ff == ST_LOAD);
   assign req_fire    = req_valid && req_ready;
   assign count_full  = (count_ff == CW'(MAX_ITEMS));
   assign load_we     = req_fire && !count_full;
   assign count_after = count_full ? count_ff : count_ff + CW'(1);

   // Segment bounds of the current merge, clamped to the sequence length.
   assign n_wide    = SW'(count_ff);
   assign width_dbl = width_ff << 1;
   assign seg_mid   = lo_ff + width_ff;
   assign seg_hi    = lo_ff + width_dbl;
   assign mid_clip  = (seg_mid > n_wide) ? count_ff : seg_mid[CW-1:0];
   assign hi_clip   = (seg_hi > n_wide) ? count_ff : seg_hi[CW-1:0];

   // The buffers are read at the next head positions, so the registered read
   // data always holds the words at i_ff and j_ff.
   assign head_left  = src_ff ? rd_b0 : rd_a0;
   assign head_right = src_ff ? rd_b1 : rd_a1;

   // Shared compare unit: the left run wins ties, which keeps the sort stable.
   assign i_live     = (i_ff < mid_ff);
   assign j_live     = (j_ff < hi_ff);
   assign take_left  = i_live && (!j_live || (head_left <= head_right));
   assign merge_data = take_left ? head_left : head_right;

   assign we_a    = load_we || ((state_ff == ST_MERGE) && src_ff);
   assign we_b    = (state_ff == ST_MERGE) && !src_ff;
   assign waddr_a = load_we ? count_ff[AW-1:0] : k_ff[AW-1:0];
   assign wdata_a = load_we ? req_value : merge_data;

   assign out_fire = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      src_in       = src_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               count_in = count_after;
               if (count_full) begin
                  drop_in = 1'b1;
               end
               if (req_is_last) begin
                  // Even a single word runs one pass, so the first read of the
                  // output comes after the closing word has been written.
                  width_in = SW'(1);
                  lo_in    = '0;
                  src_in   = 1'b0;
                  i_in     = '0;
                  state_in = ST_SEG;
               end
            end
         end

         ST_SEG: begin
            if (lo_ff >= n_wide) begin
               // End of a pass: the merged buffer becomes the source.
               width_in = width_dbl;
               lo_in    = '0;
               src_in   = !src_ff;
               if (width_dbl >= n_wide) begin
                  i_in     = '0;
                  state_in = ST_OUT;
               end
            end else begin
               mid_in   = mid_clip;
               hi_in    = hi_clip;
               i_in     = lo_ff[CW-1:0];
               j_in     = mid_clip;
               k_in     = lo_ff[CW-1:0];
               state_in = ST_MERGE;
            end
         end

         ST_MERGE: begin
            if (take_left) begin
               i_in = i_ff + CW'(1);
            end else begin
               j_in = j_ff + CW'(1);
            end
            k_in = k_ff + CW'(1);
            if (k_ff + CW'(1) == hi_ff) begin
               lo_in    = SW'(hi_ff);
               state_in = ST_SEG;
            end
         end

         ST_OUT: begin
            if (out_fire) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = head_left;
               rsp_end_in   = (i_ff + CW'(1) == count_ff);
               rsp_ovf_in   = drop_ff;
               i_in         = i_ff + CW'(1);
               if (i_ff + CW'(1) == count_ff) begin
                  // The last word is latched; get ready for the next sequence.
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         src_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      width_ff     <= width_in;
      lo_ff        <= lo_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   msb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ITEMS)
   ) u_ram_a (
      .clock   (clock),
      .we      (we_a),
      .waddr   (waddr_a),
      .wdata   (wdata_a),
      .raddr_a (i_in[AW-1:0]),
      .raddr_b (j_in[AW-1:0]),
      .rdata_a (rd_a0),
      .rdata_b (rd_a1)
   );

   msb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ITEMS)
   ) u_ram_b (
      .clock   (clock),
      .we      (we_b),
      .waddr   (k_ff[AW-1:0]),
      .wdata   (merge_data),
      .raddr_a (i_in[AW-1:0]),
      .raddr_b (j_in[AW-1:0]),
      .rdata_a (rd_b0),
      .rdata_b (rd_b1)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_run   = rsp_end_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule
